[sv/assert_macros.svh]
// Assertion macros shared by the parser RTL.
// Depends on nothing; simulation builds get the checks and synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NORST(label, clk, prop, msg)
`endif
`endif

[sv/ccrp_pkg.sv]
// Types and constants for the character class range parser.
// Used by ccrp_step and char_class_range_parser; depends on nothing.
package ccrp_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [15:0] range_low;
      logic [15:0] range_high;
      logic        range_present;
      logic        class_negated;
      logic        leading_dash;
      logic        final_result;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_AFTER_CARET,
      PH_IDLE,
      PH_PENDING,
      PH_ESC,
      PH_HEX,
      PH_DRAIN
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] range_start;
      logic [15:0] code_accum;
      logic [1:0]  hex_cnt;
      logic        negated;
      logic        leading_dash;
      logic        reading_second;
   } state_type;

   typedef struct packed {
      logic    first_valid;
      rsp_type first_rsp;
      logic    second_valid;
      rsp_type second_rsp;
   } step_out_type;

   localparam state_type STATE_RESET = '{
      phase:          PH_START,
      range_start:    16'h0000,
      code_accum:     16'h0000,
      hex_cnt:        2'd0,
      negated:        1'b0,
      leading_dash:   1'b0,
      reading_second: 1'b0
   };

   localparam logic [1:0] STATUS_OK            = 2'd0;
   localparam logic [1:0] STATUS_DANGLING_ESC  = 2'd1;
   localparam logic [1:0] STATUS_BAD_HEX       = 2'd2;
   localparam logic [1:0] STATUS_TRAILING_DASH = 2'd3;

   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_V      = 8'h76;

   localparam logic [15:0] CODE_CR  = 16'd13;
   localparam logic [15:0] CODE_LF  = 16'd10;
   localparam logic [15:0] CODE_TAB = 16'd9;
   localparam logic [15:0] CODE_VT  = 16'd11;

   // Count value held while the fourth hex digit arrives.
   localparam logic [1:0] HEX_LAST = 2'd3;

   localparam int RSP_DEPTH = 4;
   localparam int PTR_W     = 2;
   localparam int CNT_W     = 3;

endpackage

[sv/ccrp_step.sv]
// Next-state and result logic for one byte of the class body.
// Depends on ccrp_pkg; purely combinational, used by char_class_range_parser.
module ccrp_step (
   input  ccrp_pkg::state_type    cur_state,
   input  ccrp_pkg::req_type      item,
   output ccrp_pkg::state_type    next_state,
   output ccrp_pkg::step_out_type results
);
   import ccrp_pkg::*;

   // Returns {valid, value}.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'b0_0000;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   state_type   nx;
   logic        last;
   logic        begin_char;
   logic        done_char;
   logic        pend_emit;
   logic        drain_after;
   logic [15:0] cval;
   logic [4:0]  hexd;
   logic        ev;
   logic [15:0] elo;
   logic [15:0] ehi;
   logic        epres;
   logic        efin;
   logic [1:0]  estat;
   rsp_type     main_rsp;
   rsp_type     pend_rsp;

   assign last = item.end_of_text;
   assign hexd = hex_decode(item.text_byte);

   always_comb begin
      nx          = cur_state;
      begin_char  = 1'b0;
      done_char   = 1'b0;
      pend_emit   = 1'b0;
      drain_after = 1'b0;
      cval        = 16'h0000;
      ev          = 1'b0;
      elo         = 16'h0000;
      ehi         = 16'h0000;
      epres       = 1'b0;
      efin        = 1'b1;
      estat       = STATUS_OK;

      case (cur_state.phase)
         PH_START: begin
            if (item.text_byte == CHAR_CARET) begin
               nx.negated = 1'b1;
               if (last) ev = 1'b1;
               else nx.phase = PH_AFTER_CARET;
            end else if (item.text_byte == CHAR_DASH) begin
               nx.leading_dash = 1'b1;
               if (last) ev = 1'b1;
               else nx.phase = PH_IDLE;
            end else begin
               nx.phase   = PH_IDLE;
               begin_char = 1'b1;
            end
         end
         PH_AFTER_CARET: begin
            if (item.text_byte == CHAR_DASH) begin
               nx.leading_dash = 1'b1;
               if (last) ev = 1'b1;
               else nx.phase = PH_IDLE;
            end else begin
               begin_char = 1'b1;
            end
         end
         PH_IDLE: begin
            begin_char = 1'b1;
         end
         PH_PENDING: begin
            if (item.text_byte == CHAR_DASH) begin
               if (last) begin
                  ev    = 1'b1;
                  estat = STATUS_TRAILING_DASH;
               end else begin
                  nx.reading_second = 1'b1;
                  nx.phase          = PH_IDLE;
               end
            end else begin
               // The held char was a single; it leaves ahead of this byte's result.
               pend_emit  = 1'b1;
               nx.phase   = PH_IDLE;
               begin_char = 1'b1;
            end
         end
         PH_ESC: begin
            if (item.text_byte == CHAR_U) begin
               if (last) begin
                  ev    = 1'b1;
                  estat = STATUS_DANGLING_ESC;
               end else begin
                  nx.code_accum = 16'h0000;
                  nx.hex_cnt    = 2'd0;
                  nx.phase      = PH_HEX;
               end
            end else begin
               done_char = 1'b1;
               case (item.text_byte)
                  CHAR_R:  cval = CODE_CR;
                  CHAR_N:  cval = CODE_LF;
                  CHAR_T:  cval = CODE_TAB;
                  CHAR_V:  cval = CODE_VT;
                  default: cval = {8'h00, item.text_byte};
               endcase
            end
         end
         PH_HEX: begin
            if (!hexd[4]) begin
               ev          = 1'b1;
               estat       = STATUS_BAD_HEX;
               drain_after = !last;
            end else begin
               nx.code_accum = {cur_state.code_accum[11:0], hexd[3:0]};
               if (cur_state.hex_cnt == HEX_LAST) begin
                  nx.hex_cnt = 2'd0;
                  done_char  = 1'b1;
                  cval       = nx.code_accum;
               end else begin
                  nx.hex_cnt = cur_state.hex_cnt + 2'd1;
                  if (last) begin
                     ev    = 1'b1;
                     estat = STATUS_DANGLING_ESC;
                  end
               end
            end
         end
         PH_DRAIN: begin
            if (last) nx = STATE_RESET;
         end
         default: begin
            nx = STATE_RESET;
         end
      endcase

      if (begin_char) begin
         if (item.text_byte == CHAR_BSLASH) begin
            if (last) begin
               ev    = 1'b1;
               estat = STATUS_DANGLING_ESC;
            end else begin
               nx.phase = PH_ESC;
            end
         end else begin
            done_char = 1'b1;
            cval      = {8'h00, item.text_byte};
         end
      end

      if (done_char) begin
         if (nx.reading_second) begin
            nx.reading_second = 1'b0;
            nx.phase          = PH_IDLE;
            ev                = 1'b1;
            elo               = nx.range_start;
            ehi               = cval;
            epres             = 1'b1;
            efin              = last;
         end else if (last) begin
            ev    = 1'b1;
            elo   = cval;
            ehi   = cval;
            epres = 1'b1;
         end else begin
            nx.range_start = cval;
            nx.phase       = PH_PENDING;
         end
      end

      // Flags are sampled before a final result wipes the class state.
      main_rsp = '{
         range_low:     elo,
         range_high:    ehi,
         range_present: epres,
         class_negated: nx.negated,
         leading_dash:  nx.leading_dash,
         final_result:  efin,
         status:        estat
      };
      pend_rsp = '{
         range_low:     cur_state.range_start,
         range_high:    cur_state.range_start,
         range_present: 1'b1,
         class_negated: cur_state.negated,
         leading_dash:  cur_state.leading_dash,
         final_result:  1'b0,
         status:        STATUS_OK
      };

      if (pend_emit) begin
         results = '{first_valid: 1'b1, first_rsp: pend_rsp,
                     second_valid: ev, second_rsp: main_rsp};
      end else begin
         results = '{first_valid: ev, first_rsp: main_rsp,
                     second_valid: 1'b0, second_rsp: main_rsp};
      end

      if (ev && efin) begin
         nx = STATE_RESET;
         if (drain_after) nx.phase = PH_DRAIN;
      end

      next_state = nx;
   end

endmodule

[sv/char_class_range_parser.sv]
// Top level of the bracket character class range parser.
// Depends on ccrp_pkg, ccrp_step and assert_macros.svh.
//
// Usage: bytes of a class body enter on the req_ channel, one item per byte, with
// end_of_text set on the last byte. Ranges leave on the rsp_ channel in order; the
// last result of a class has final_result set, and an error ends the class at once.
// An item is taken at a clock edge where its valid is high and its stall is low.
// A byte taken at an edge is held in the input stage and decoded from there once the queue
// has room; its results are written to the result queue, which drives rsp_.
// Throughput: one byte per cycle while the receiver keeps up; a byte that closes a
// held single yields a second result, and both results leave rsp_ in turn. The
// four-entry result queue behind the decode stage sets this: decoding waits until
// two slots are free. Reset is synchronous: it empties the input stage and the queue
// and starts a new class. When rsp_stall is high the queue fills; once it holds three
// or more results the byte in the input stage waits and req_stall rises. How many
// bytes get in before that depends on how many results they cause; nothing is dropped.
`include "assert_macros.svh"

module char_class_range_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ccrp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ccrp_pkg::rsp_type rsp_data
);
   import ccrp_pkg::*;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   req_type          s1_item_ff;
   state_type        state_ff;
   state_type        state_in;
   state_type        step_next;
   step_out_type     step_res;
   rsp_type          rsp_mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             fire;
   logic             accept;
   logic             push0;
   logic             push1;
   logic             pop;

   ccrp_step u_step (
      .cur_state  (state_ff),
      .item       (s1_item_ff),
      .next_state (step_next),
      .results    (step_res)
   );

   // Decode only when the queue can take both possible results.
   assign fire      = s1_valid_ff && (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign req_stall = s1_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !fire);

   assign push0 = fire && step_res.first_valid;
   assign push1 = fire && step_res.second_valid;
   assign pop   = rsp_valid && !rsp_stall;

   assign state_in    = fire ? step_next : state_ff;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + PTR_W'(push0) + PTR_W'(push1);
   assign rd_ptr_in   = rd_ptr_ff + PTR_W'(pop);
   assign count_in    = count_ff + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = rsp_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         state_ff    <= state_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         rsp_mem_ff[wr_ptr_ff] <= step_res.first_rsp;
      end
      if (push1) begin
         rsp_mem_ff[wr_ptr_next] <= step_res.second_rsp;
      end
   end

   `ASSERT_CLK(a_queue_bound, clock, reset,
      count_ff <= CNT_W'(RSP_DEPTH),
      "result queue overflow")
   `ASSERT_CLK(a_hex_count_phase, clock, reset,
      (state_ff.hex_cnt != 2'd0) |-> (state_ff.phase == PH_HEX),
      "hex digit count outside hex escape")
   `ASSERT_CLK(a_second_phase, clock, reset,
      state_ff.reading_second |-> ((state_ff.phase == PH_IDLE) ||
         (state_ff.phase == PH_ESC) || (state_ff.phase == PH_HEX)),
      "range end expected in wrong phase")
   `ASSERT_CLK(a_final_restarts, clock, reset,
      ((push0 && step_res.first_rsp.final_result) ||
         (push1 && step_res.second_rsp.final_result)) |=>
         ((state_ff.phase == PH_START) || (state_ff.phase == PH_DRAIN)),
      "class state not restarted after final result")
   `ASSERT_CLK(a_empty_stays_empty, clock, reset,
      ((count_ff == '0) && !fire) |=> !rsp_valid,
      "result appeared without a decode")

endmodule

[bench/char_class_range_parser_tb.sv]
// Self-checking bench for char_class_range_parser: byte streams of bracket class bodies go in,
// an in-bench decoder predicts every range and status item, and a checker compares each field.
// Depends on ccrp_pkg and the char_class_range_parser RTL only.
module char_class_range_parser_tb;
   import ccrp_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   char_class_range_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decoder state kept by the bench.
   phase_type   parse_phase;
   logic [15:0] held_start;
   logic [15:0] hex_accum;
   int unsigned hex_count;
   logic        seen_caret;
   logic        seen_dash;
   logic        want_second;

   rsp_type     expected_ranges[$];
   logic [7:0]  class_bytes[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int long_hold_len = 0;
   int hold_countdown = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int classes_sent = 0;
   int ranges_checked = 0;
   int markers_checked = 0;

   function automatic void clear_parser();
      parse_phase = PH_START;
      held_start  = '0;
      hex_accum   = '0;
      hex_count   = 0;
      seen_caret  = 1'b0;
      seen_dash   = 1'b0;
      want_second = 1'b0;
   endfunction

   function automatic void expect_range(input logic [15:0] lo, input logic [15:0] hi,
                                        input logic present, input logic fin,
                                        input logic [1:0] status);
      rsp_type r;
      r.range_low     = lo;
      r.range_high    = hi;
      r.range_present = present;
      r.class_negated = seen_caret;
      r.leading_dash  = seen_dash;
      r.final_result  = fin;
      r.status        = status;
      expected_ranges.insert(expected_ranges.size(), r);
      if (fin)
         clear_parser();
   endfunction

   function automatic void finish_char(input logic [15:0] c, input logic last);
      if (want_second) begin
         want_second = 1'b0;
         parse_phase = PH_IDLE;
         expect_range(held_start, c, 1'b1, last, STATUS_OK);
      end else if (last) begin
         expect_range(c, c, 1'b1, 1'b1, STATUS_OK);
      end else begin
         held_start  = c;
         parse_phase = PH_PENDING;
      end
   endfunction

   function automatic void begin_char(input logic [7:0] b, input logic last);
      if (b == CHAR_BSLASH) begin
         if (last)
            expect_range('0, '0, 1'b0, 1'b1, STATUS_DANGLING_ESC);
         else
            parse_phase = PH_ESC;
      end else begin
         finish_char({8'h00, b}, last);
      end
   endfunction

   function automatic int hex_digit_value(input logic [7:0] b);
      if (b >= "0" && b <= "9")
         return int'(b - "0");
      if (b >= "a" && b <= "f")
         return int'(b - "a") + 10;
      if (b >= "A" && b <= "F")
         return int'(b - "A") + 10;
      return -1;
   endfunction

   // Works out the results that one accepted byte causes.
   function automatic void predict_byte(input logic [7:0] b, input logic last);
      int d;
      case (parse_phase)
         PH_START, PH_AFTER_CARET: begin
            if (parse_phase == PH_START && b == CHAR_CARET) begin
               seen_caret = 1'b1;
               if (last)
                  expect_range('0, '0, 1'b0, 1'b1, STATUS_OK);
               else
                  parse_phase = PH_AFTER_CARET;
            end else if (b == CHAR_DASH) begin
               seen_dash = 1'b1;
               if (last)
                  expect_range('0, '0, 1'b0, 1'b1, STATUS_OK);
               else
                  parse_phase = PH_IDLE;
            end else begin
               parse_phase = PH_IDLE;
               begin_char(b, last);
            end
         end
         PH_IDLE: begin
            begin_char(b, last);
         end
         PH_PENDING: begin
            if (b == CHAR_DASH) begin
               if (last) begin
                  expect_range('0, '0, 1'b0, 1'b1, STATUS_TRAILING_DASH);
               end else begin
                  want_second = 1'b1;
                  parse_phase = PH_IDLE;
               end
            end else begin
               expect_range(held_start, held_start, 1'b1, 1'b0, STATUS_OK);
               parse_phase = PH_IDLE;
               begin_char(b, last);
            end
         end
         PH_ESC: begin
            if (b == CHAR_U) begin
               if (last) begin
                  expect_range('0, '0, 1'b0, 1'b1, STATUS_DANGLING_ESC);
               end else begin
                  hex_accum   = '0;
                  hex_count   = 0;
                  parse_phase = PH_HEX;
               end
            end else if (b == CHAR_R) begin
               finish_char(CODE_CR, last);
            end else if (b == CHAR_N) begin
               finish_char(CODE_LF, last);
            end else if (b == CHAR_T) begin
               finish_char(CODE_TAB, last);
            end else if (b == CHAR_V) begin
               finish_char(CODE_VT, last);
            end else begin
               finish_char({8'h00, b}, last);
            end
         end
         PH_HEX: begin
            d = hex_digit_value(b);
            if (d < 0) begin
               expect_range('0, '0, 1'b0, 1'b1, STATUS_BAD_HEX);
               if (!last)
                  parse_phase = PH_DRAIN;
            end else begin
               hex_accum = {hex_accum[11:0], 4'(d)};
               hex_count++;
               if (hex_count >= 4) begin
                  hex_count = 0;
                  finish_char(hex_accum, last);
               end else if (last) begin
                  expect_range('0, '0, 1'b0, 1'b1, STATUS_DANGLING_ESC);
               end
            end
         end
         default: begin
            // Bytes after a bad hex digit are dropped up to the end of the class.
            if (last)
               clear_parser();
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (error_count < 30)
         $display("[%0t] mismatch in %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch(name, got, want);
   endtask

   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ranges.size() == 0) begin
            report_mismatch("item with nothing expected", rsp_data.range_low, '0);
         end else begin
            want = expected_ranges.pop_front();
            check_field("range_low", rsp_data.range_low, want.range_low);
            check_field("range_high", rsp_data.range_high, want.range_high);
            check_field("range_present", 16'(rsp_data.range_present), 16'(want.range_present));
            check_field("class_negated", 16'(rsp_data.class_negated), 16'(want.class_negated));
            check_field("leading_dash", 16'(rsp_data.leading_dash), 16'(want.leading_dash));
            check_field("final_result", 16'(rsp_data.final_result), 16'(want.final_result));
            check_field("status", 16'(rsp_data.status), 16'(want.status));
            if (want.range_present)
               ranges_checked++;
            else
               markers_checked++;
         end
      end
   end

   // Receiver side: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (long_hold_len != 0) begin
         hold_countdown = long_hold_len;
         long_hold_len = 0;
      end
      if (hold_countdown > 0) begin
         hold_countdown--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Called just after a rising edge; returns at the edge that accepts the item.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'{text_byte: b, end_of_text: last};
      do @(posedge clock); while (req_stall);
      predict_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_class_bytes();
      foreach (class_bytes[i])
         send_byte(class_bytes[i], i == class_bytes.size() - 1);
      classes_sent++;
   endtask

   // Appends one byte to the class being built.
   function automatic void add_byte(input logic [7:0] c);
      class_bytes.insert(class_bytes.size(), c);
   endfunction

   function automatic logic [7:0] random_hex_digit();
      string digits = "0123456789abcdefABCDEF";
      case ($urandom_range(0, 4))
         0: return "0";
         1: return $urandom_range(0, 1) ? "f" : "F";
         default: return digits[$urandom_range(0, 21)];
      endcase
   endfunction

   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (hex_digit_value(c) >= 0);
      return c;
   endfunction

   function automatic void push_element();
      logic [7:0] c;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         do c = 8'($urandom_range(0, 255)); while (c == CHAR_BSLASH);
         add_byte(c);
      end else if (pick < 7) begin
         add_byte(CHAR_BSLASH);
         case ($urandom_range(0, 4))
            0: add_byte(CHAR_R);
            1: add_byte(CHAR_N);
            2: add_byte(CHAR_T);
            3: add_byte(CHAR_V);
            default: begin
               do c = 8'($urandom_range(0, 255)); while (c == CHAR_U);
               add_byte(c);
            end
         endcase
      end else begin
         add_byte(CHAR_BSLASH);
         add_byte(CHAR_U);
         repeat (4) add_byte(random_hex_digit());
      end
   endfunction

   // Mostly well-formed classes with random content; some end broken, a few are pure noise.
   function automatic void build_random_class();
      int kind;
      class_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 3) == 0)
         add_byte(CHAR_CARET);
      if ($urandom_range(0, 4) == 0)
         add_byte(CHAR_DASH);
      repeat ($urandom_range(0, 5)) begin
         push_element();
         if ($urandom_range(0, 2) == 0) begin
            add_byte(CHAR_DASH);
            push_element();
         end
      end
      if (kind >= 78) begin
         case ($urandom_range(0, 3))
            0: add_byte(CHAR_BSLASH);
            1: begin
               add_byte(CHAR_BSLASH);
               add_byte(CHAR_U);
               repeat ($urandom_range(0, 3)) add_byte(random_hex_digit());
            end
            2: begin
               add_byte(CHAR_BSLASH);
               add_byte(CHAR_U);
               repeat ($urandom_range(0, 3)) add_byte(random_hex_digit());
               add_byte(random_non_hex());
               repeat ($urandom_range(0, 4))
                  add_byte(8'($urandom_range(0, 255)));
            end
            default: begin
               push_element();
               add_byte(CHAR_DASH);
            end
         endcase
      end
      if (class_bytes.size() == 0)
         push_element();
   endfunction

   task automatic test_directed_classes();
      // Caret, leading dash, escaped control code up to the top code point.
      class_bytes = '{CHAR_CARET, CHAR_DASH, CHAR_BSLASH, CHAR_R, CHAR_DASH,
                      CHAR_BSLASH, CHAR_U, "f", "f", "F", "F"};
      send_class_bytes();
      // A lone backslash as the last byte.
      class_bytes = '{CHAR_BSLASH};
      send_class_bytes();
      // A bad hex digit, then a byte that is dropped.
      class_bytes = '{CHAR_BSLASH, CHAR_U, "g", "x"};
      send_class_bytes();
      // Lowest and highest byte, then a dash that ends the class.
      class_bytes = '{8'h00, 8'hFF, CHAR_DASH};
      send_class_bytes();
      class_bytes = '{CHAR_BSLASH, CHAR_N, CHAR_BSLASH, CHAR_T, CHAR_BSLASH, CHAR_V};
      send_class_bytes();
      // Only a caret: the class ends with no range.
      class_bytes = '{CHAR_CARET};
      send_class_bytes();
   endtask

   task automatic test_random_classes(input int n_bytes, input int send_pct,
                                      input int stall_pct);
      int start_count;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      start_count = bytes_sent;
      while (bytes_sent - start_count < n_bytes) begin
         build_random_class();
         send_class_bytes();
      end
   endtask

   task automatic test_long_receiver_hold();
      // The receiver holds off while bytes keep coming, so the result queue fills.
      long_hold_len = 250;
      test_random_classes(60, 0, 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      clear_parser();
      test_directed_classes();
      test_random_classes(140, 0, 0);
      test_random_classes(140, 52, 0);
      test_random_classes(140, 0, 52);
      test_random_classes(140, 23, 23);
      test_long_receiver_hold();
      req_valid <= 1'b0;
      while (expected_ranges.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes in %0d classes under several idle and stall mixes.",
               bytes_sent, classes_sent);
      $display("Checked %0d ranges and %0d end or error items; %0d mismatches.",
               ranges_checked, markers_checked, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d items still expected.", expected_ranges.size());
      $display("FAILURE");
      $finish;
   end

endmodule
